@@ design/wbps_pkg.sv @@
package wbps_pkg;

	// Defaults for the top-level parameters.
	localparam int PatternMaxDefault = 32;
	localparam int OffsetBitsDefault = 32;

	// Configuration port.
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 64;
	localparam int PatRegs  = 4;

	// Register indexes on the configuration port.
	localparam logic [CfgIdxW-1:0] RegPattern0   = 3'd0;
	localparam logic [CfgIdxW-1:0] RegPattern1   = 3'd1;
	localparam logic [CfgIdxW-1:0] RegPattern2   = 3'd2;
	localparam logic [CfgIdxW-1:0] RegPattern3   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegWildMask   = 3'd4;
	localparam logic [CfgIdxW-1:0] RegPatternLen = 3'd5;
	localparam logic [CfgIdxW-1:0] RegCaseFold   = 3'd6;

	// Pattern bytes held in the configuration registers.
	localparam int PatStoredBytes = 32;

	// ASCII codes used for case folding.
	localparam logic [7:0] CharUpperA = 8'h41;
	localparam logic [7:0] CharUpperZ = 8'h5A;
	localparam logic [7:0] CharLowerA = 8'h61;

	typedef struct packed {
		logic advance;
		logic flush;
		logic clear;
		logic fold_en;
	} cell_ctrl_t;

	typedef struct packed {
		logic        match_hit;
		logic [31:0] match_offset;
		logic        scan_done;
		logic [31:0] match_total;
	} result_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
		logic [7:0] r;
		r = c;
		if (en && c >= CharUpperA && c <= CharUpperZ) begin
			r = c - CharUpperA + CharLowerA;
		end
		return r;
	endfunction

endpackage

@@ design/wildcard_byte_pattern_scanner.sv @@
// A result is registered in the output buffer when the byte that causes it is accepted.
// One byte is taken per cycle while the skid entry is empty.
// Results wait in an output register backed by one skid entry; input stalls only
// when both are full. Reset clears the pattern registers (length one, no wildcards,
// no folding), the cell row, the byte position and the match count; no sweep is needed.
module wildcard_byte_pattern_scanner #(
	parameter int PATTERN_MAX = wbps_pkg::PatternMaxDefault,
	parameter int OFFSET_BITS = wbps_pkg::OffsetBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          buffer_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          match_hit,
	output logic [31:0]                   match_offset,
	output logic                          scan_done,
	output logic [31:0]                   match_total,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [wbps_pkg::CfgDataW-1:0] cfg_data
);

	localparam int LenW     = $clog2(PATTERN_MAX + 1);
	localparam int IdxW     = $clog2(PATTERN_MAX);
	localparam int WinDepth = PATTERN_MAX - 1;

	// Configuration registers. The user must write them only while the scanner is
	// idle; the block itself does not enforce this. Writes are always accepted.
	logic [wbps_pkg::CfgDataW-1:0] pat_q [wbps_pkg::PatRegs];
	logic [31:0]                   wild_q;
	logic [5:0]                    len_q;
	logic                          fold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < wbps_pkg::PatRegs; r++) begin
				pat_q[r] <= '0;
			end
			wild_q <= '0;
			len_q  <= 6'd1;
			fold_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				wbps_pkg::RegPattern0:   pat_q[0] <= cfg_data;
				wbps_pkg::RegPattern1:   pat_q[1] <= cfg_data;
				wbps_pkg::RegPattern2:   pat_q[2] <= cfg_data;
				wbps_pkg::RegPattern3:   pat_q[3] <= cfg_data;
				wbps_pkg::RegWildMask:   wild_q   <= cfg_data[31:0];
				wbps_pkg::RegPatternLen: len_q    <= cfg_data[5:0];
				wbps_pkg::RegCaseFold:   fold_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Scan state outside the cell row.
	logic [OFFSET_BITS-1:0] pos_q;
	logic [31:0]            count_q;

	logic                   in_fire;
	logic                   can_push;
	logic [7:0]             data_fold;
	logic [LenW-1:0]        len_eff;
	logic [IdxW-1:0]        len_sel;
	logic                   head_ok;
	logic                   hit_any;
	logic [OFFSET_BITS-1:0] start_pos;
	logic [31:0]            count_nxt;
	logic                   res_push;
	wbps_pkg::result_t      res;
	wbps_pkg::result_t      out_data;
	wbps_pkg::cell_ctrl_t   cell_ctrl;

	logic [PATTERN_MAX-1:0][7:0] pat_vec;
	logic [PATTERN_MAX-1:0]      wild_vec;
	logic [WinDepth-1:0][7:0]    win_q;
	logic [WinDepth-1:0]         fill_vec_q;
	logic [WinDepth-1:0]         ok_vec;

	assign in_ready  = can_push;
	assign in_fire   = in_valid && in_ready;
	assign data_fold = wbps_pkg::fold_byte(data_byte, fold_q);

	// Lengths beyond the cell row are treated as the full row.
	always_comb begin
		if (32'(len_q) > 32'(PATTERN_MAX)) begin
			len_eff = LenW'(PATTERN_MAX);
		end else begin
			len_eff = LenW'(len_q);
		end
	end

	// Pattern bytes as one vector; positions past the registers are zero
	// bytes and never wildcards.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
		if (k < wbps_pkg::PatStoredBytes) begin : g_stored
			assign pat_vec[k]  = pat_q[k >> 3][(k & 7) * 8 +: 8];
			assign wild_vec[k] = wild_q[k];
		end else begin : g_beyond
			assign pat_vec[k]  = 8'h00;
			assign wild_vec[k] = 1'b0;
		end
	end

	// The incoming byte lines up with the last pattern byte in use.
	assign len_sel = IdxW'(len_eff - 1'b1);
	assign head_ok = wild_vec[len_sel] ||
		(wbps_pkg::fold_byte(pat_vec[len_sel], fold_q) == data_fold);

	// Cell j holds the byte taken j+1 transfers ago and a flag that is set when
	// that byte came after the buffer start or the last match. The flags form a
	// thermometer, so the window holds enough fresh bytes exactly when every
	// cell in use has its flag set. Each cell compares its byte against the
	// pattern byte that the current length aligns with it, so a change of the
	// pattern, the length or the folding applies to the bytes already held.
	// A match clears the flags, so matches never overlap; the end of a buffer
	// clears the whole row.
	assign cell_ctrl.advance = in_fire;
	assign cell_ctrl.flush   = hit_any;
	assign cell_ctrl.clear   = buffer_end;
	assign cell_ctrl.fold_en = fold_q;

	for (genvar j = 0; j < WinDepth; j++) begin : g_cell
		logic [IdxW-1:0] cell_sel;
		logic            cell_use;
		logic [7:0]      cell_prev_byte;
		logic            cell_prev_fill;

		assign cell_use = (len_eff >= LenW'(j + 2));
		assign cell_sel = IdxW'(len_eff - LenW'(j + 2));

		if (j == 0) begin : g_head
			assign cell_prev_byte = data_byte;
			assign cell_prev_fill = 1'b1;
		end else begin : g_link
			assign cell_prev_byte = win_q[j-1];
			assign cell_prev_fill = fill_vec_q[j-1];
		end

		wbps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.prev_byte (cell_prev_byte),
			.prev_fill (cell_prev_fill),
			.pat_byte  (pat_vec[cell_sel]),
			.pat_wild  (wild_vec[cell_sel]),
			.in_use    (cell_use),
			.byte_q    (win_q[j]),
			.fill_q    (fill_vec_q[j]),
			.cell_ok   (ok_vec[j])
		);
	end

	// A zero length never matches.
	assign hit_any = (len_eff != '0) && head_ok && (&ok_vec);

	// The match began len-1 bytes before the current one; offsets wrap.
	assign start_pos = pos_q - (OFFSET_BITS'(len_eff) - 1'b1);

	always_comb begin
		count_nxt = count_q;
		if (hit_any && count_q != '1) begin
			count_nxt = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
		end else if (in_fire) begin
			if (buffer_end) begin
				pos_q   <= '0;
				count_q <= '0;
			end else begin
				pos_q   <= pos_q + 1'b1;
				count_q <= count_nxt;
			end
		end
	end

	// A transfer yields a result when a match ends on it or it closes the buffer.
	assign res_push         = in_fire && (hit_any || buffer_end);
	assign res.match_hit    = hit_any;
	assign res.match_offset = hit_any ? 32'(start_pos) : 32'd0;
	assign res.scan_done    = buffer_end;
	assign res.match_total  = count_nxt;

	wbps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign match_hit    = out_data.match_hit;
	assign match_offset = out_data.match_offset;
	assign scan_done    = out_data.scan_done;
	assign match_total  = out_data.match_total;

`ifndef SYNTHESIS
	// A reported match always counts at least one match in the buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && match_hit) |-> (match_total != 32'd0))
		else $error("match reported with zero match count");

	// Closing a buffer restarts the byte position and empties the window.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && buffer_end) |=> (pos_q == '0 && win_q == '0))
		else $error("scan state not cleared at buffer end");

	// After a match no held byte counts toward the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && hit_any) |=> (fill_vec_q == '0))
		else $error("window fill not cleared after a match");

	// Input stalls only while a result is waiting downstream.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output register");
`endif

endmodule

@@ design/wbps_cell.sv @@
// One slot of the byte window: holds one earlier byte and whether it was taken
// since the buffer start or the last match, shifts both on to the next slot, and
// checks its byte against the pattern byte currently aligned with it.
module wbps_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wbps_pkg::cell_ctrl_t   ctrl,
	input  logic [7:0]             prev_byte,
	input  logic                   prev_fill,
	input  logic [7:0]             pat_byte,
	input  logic                   pat_wild,
	input  logic                   in_use,
	output logic [7:0]             byte_q,
	output logic                   fill_q,
	output logic                   cell_ok
);

	logic byte_eq;

	assign byte_eq = pat_wild || (wbps_pkg::fold_byte(pat_byte, ctrl.fold_en) ==
		wbps_pkg::fold_byte(byte_q, ctrl.fold_en));
	assign cell_ok = !in_use || (fill_q && byte_eq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
			fill_q <= 1'b0;
		end else if (ctrl.advance) begin
			if (ctrl.clear) begin
				byte_q <= 8'h00;
				fill_q <= 1'b0;
			end else begin
				byte_q <= prev_byte;
				fill_q <= ctrl.flush ? 1'b0 : prev_fill;
			end
		end
	end

endmodule

@@ design/wbps_out_buf.sv @@
// Output register with one skid entry, so the input side sees a registered ready.
module wbps_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wbps_pkg::result_t push_data,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output wbps_pkg::result_t out_data
);

	logic              out_valid_q;
	logic              skid_valid_q;
	wbps_pkg::result_t out_q;
	wbps_pkg::result_t skid_q;
	logic              stalled;

	assign stalled   = out_valid_q && !out_ready;
	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (stalled) begin
			if (push) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= push;
		end else begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (stalled) begin
			if (push) begin
				skid_q <= push_data;
			end
		end else if (skid_valid_q) begin
			out_q  <= skid_q;
			skid_q <= push_data;
		end else begin
			out_q <= push_data;
		end
	end

endmodule

@@ test/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Index 7 is not a register; writes to it must leave every register alone.
	localparam logic [wbps_pkg::CfgIdxW-1:0] RegUnused = 3'd7;
	localparam int WinDepth = wbps_pkg::PatternMaxDefault - 1;
	localparam int PatMax = wbps_pkg::PatternMaxDefault;
	localparam int IdlePct = 6;
	localparam int NumPhases = 16;
	localparam int PhaseBytes = 115;
	// A small set of characters around the folding range: both cases of a few
	// letters, both ends of A-Z, and the two neighbors just outside it.
	localparam logic [63:0] Alphabet = {8'h5B, 8'h40, 8'h7A, 8'h5A, 8'h42, 8'h62, 8'h41, 8'h61};

	typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_FIXED} row_kind_t;

	// One row of the directed table: a register write, a byte checked against
	// the scan predictor, or a byte whose result is typed in by hand.
	typedef struct {
		row_kind_t                     kind;
		logic [wbps_pkg::CfgIdxW-1:0]  idx;
		logic [wbps_pkg::CfgDataW-1:0] val;
		logic [7:0]                    b;
		logic                          last;
		wbps_pkg::result_t             res;
	} stim_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [7:0]                    data_byte = '0;
	logic                          buffer_end = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          match_hit;
	logic [31:0]                   match_offset;
	logic                          scan_done;
	logic [31:0]                   match_total;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [wbps_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [wbps_pkg::CfgDataW-1:0] cfg_data = '0;

	// Shadow copy of the configuration registers.
	logic [63:0] pat_reg [wbps_pkg::PatRegs];
	logic [31:0] wild_bits = '0;
	logic [5:0]  pat_len = 6'd1;
	logic        fold_on = 1'b0;

	// Shadow copy of the scan state of the current buffer.
	logic [7:0]  win [WinDepth];
	logic [31:0] pos;
	int unsigned fill;
	logic [31:0] hits_in_buf;

	// Results still owed by the block, oldest first.
	wbps_pkg::result_t pending_q [$];
	wbps_pkg::result_t oldest;
	stim_row_t         dir_rows [$];
	bit                calm = 1'b0;
	bit                narrow = 1'b0;
	int unsigned       fail_cnt = 0;

	wildcard_byte_pattern_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.buffer_end   (buffer_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.match_hit    (match_hit),
		.match_offset (match_offset),
		.scan_done    (scan_done),
		.match_total  (match_total),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Case folding as the compare sees it: upper-case letters gain bit 5 when
	// folding is on, everything else passes through.
	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (fold_on && c >= wbps_pkg::CharUpperA && c <= wbps_pkg::CharUpperZ) ?
			(c | 8'h20) : c;
	endfunction

	function automatic void clear_scan_state();
		foreach (win[k]) win[k] = '0;
		pos = '0;
		fill = 0;
		hits_in_buf = '0;
	endfunction

	function automatic void apply_cfg(input logic [wbps_pkg::CfgIdxW-1:0] idx,
			input logic [wbps_pkg::CfgDataW-1:0] v);
		case (idx)
			wbps_pkg::RegPattern0, wbps_pkg::RegPattern1, wbps_pkg::RegPattern2,
			wbps_pkg::RegPattern3: pat_reg[idx[1:0]] = v;
			wbps_pkg::RegWildMask: wild_bits = v[31:0];
			wbps_pkg::RegPatternLen: pat_len = v[5:0];
			wbps_pkg::RegCaseFold: fold_on = v[0];
			default: ;
		endcase
	endfunction

	// Takes one byte into the shadow scan state. Returns 1 when the byte owes a
	// result (a match ends on it, or it closes the buffer) and fills r.
	function automatic bit scan_byte(input logic [7:0] b, input logic last,
			output wbps_pkg::result_t r);
		int unsigned span;
		int unsigned back;
		logic [7:0]  d;
		logic [7:0]  p;
		bit          hit;
		logic [31:0] start;
		span = (32'(pat_len) > PatMax) ? PatMax : 32'(pat_len);
		hit = 1'b0;
		start = '0;
		// A match is only possible once the window holds enough bytes taken
		// since the buffer start or the previous match.
		if (span > 0 && fill >= span - 1) begin
			hit = 1'b1;
			for (int i = 0; i < span; i++) begin
				back = span - 1 - i;
				d = (back == 0) ? b : win[back-1];
				p = pat_reg[i/8][(i%8)*8 +: 8];
				if (!wild_bits[i] && to_lower(p) != to_lower(d)) hit = 1'b0;
			end
			start = pos - (span - 1);
		end
		if (hit) begin
			if (hits_in_buf != '1) hits_in_buf++;
			fill = 0;
		end else if (fill < WinDepth) begin
			fill++;
		end
		for (int k = WinDepth - 1; k > 0; k--) win[k] = win[k-1];
		win[0] = b;
		pos++;
		r.match_hit = hit;
		r.match_offset = hit ? start : '0;
		r.scan_done = last;
		r.match_total = hits_in_buf;
		if (last) clear_scan_state();
		return hit || last;
	endfunction

	function automatic logic [7:0] pick_byte();
		return narrow ? Alphabet[$urandom_range(7)*8 +: 8] : 8'($urandom_range(255));
	endfunction

	function automatic stim_row_t cfg_row(input logic [wbps_pkg::CfgIdxW-1:0] idx,
			input logic [wbps_pkg::CfgDataW-1:0] v);
		stim_row_t r;
		r = '{kind: ROW_CFG, idx: idx, val: v, b: '0, last: 1'b0, res: '0};
		return r;
	endfunction

	function automatic stim_row_t byte_row(input logic [7:0] b, input logic last);
		stim_row_t r;
		r = '{kind: ROW_PRED, idx: '0, val: '0, b: b, last: last, res: '0};
		return r;
	endfunction

	function automatic stim_row_t fixed_row(input logic [7:0] b, input logic last,
			input logic hit, input logic [31:0] off, input logic done,
			input logic [31:0] total);
		stim_row_t r;
		r = '{kind: ROW_FIXED, idx: '0, val: '0, b: b, last: last, res: '0};
		r.res.match_hit = hit;
		r.res.match_offset = off;
		r.res.scan_done = done;
		r.res.match_total = total;
		return r;
	endfunction

	// Appends one row to the directed table.
	function automatic void add_row(input stim_row_t r);
		dir_rows = {dir_rows, r};
	endfunction

	// Holds off the byte stream until every owed result has been taken, with the
	// valid line low.
	task automatic drain();
		in_valid = 1'b0;
		do @(negedge clk); while (pending_q.size() != 0);
	endtask

	// Register writes happen only with the scanner idle. A byte that owes no
	// result may still be in flight when the queue empties, so the task waits
	// for it before the write.
	task automatic write_reg(input logic [wbps_pkg::CfgIdxW-1:0] idx,
			input logic [wbps_pkg::CfgDataW-1:0] v);
		drain();
		repeat (3) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		apply_cfg(idx, v);
	endtask

	// Sends one byte and records what it owes. The call returns on the falling
	// edge after the transfer with valid still high; the caller either drives
	// the next byte or lowers valid in that same step, so the stale byte is
	// never seen at a rising edge.
	task automatic push_byte(input logic [7:0] b, input logic last, input bit fixed,
			input wbps_pkg::result_t want);
		wbps_pkg::result_t r;
		bit                owed;
		while (!calm && $urandom_range(99) < IdlePct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		buffer_end = last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		owed = scan_byte(b, last, r);
		if (fixed) pending_q = {pending_q, want};
		else if (owed) pending_q = {pending_q, r};
	endtask

	// Picks a register setting for one phase of random traffic. The first
	// phases pin the extremes; the rest are random, mostly short patterns.
	task automatic setup_phase(input int p);
		logic [wbps_pkg::CfgDataW-1:0] pr [wbps_pkg::PatRegs];
		logic [31:0]                   m;
		logic [5:0]                    l;
		logic                          f;
		int unsigned                   sel;
		narrow = 1'($urandom_range(1));
		foreach (pr[j])
			for (int k = 0; k < 8; k++) pr[j][k*8 +: 8] = pick_byte();
		sel = $urandom_range(19);
		if (sel < 10) m = '0;
		else if (sel < 17) m = $urandom & $urandom & $urandom;
		else m = $urandom;
		sel = $urandom_range(19);
		if (sel < 13) l = 6'($urandom_range(6, 1));
		else if (sel < 16) l = 6'($urandom_range(31, 7));
		else if (sel < 18) l = 6'd32;
		else if (sel == 18) l = 6'd0;
		else l = 6'($urandom_range(63, 33));
		f = 1'($urandom_range(1));
		case (p)
			// Length above the pattern size is clipped to the full size.
			0: begin
				l = 6'd63;
				m = '0;
				f = 1'b1;
			end
			// Full-length pattern made only of wildcards: every 32 bytes match.
			1: begin
				l = 6'd32;
				m = '1;
			end
			// Zero length never matches.
			2: l = 6'd0;
			3: begin
				l = 6'd1;
				pr[0][7:0] = 8'hFF;
				m = '0;
			end
			// A single wildcard byte matches every byte.
			4: begin
				l = 6'd1;
				m = 32'h1;
			end
			5: begin
				foreach (pr[j]) pr[j] = '0;
				l = 6'd32;
				m = '0;
			end
			6: begin
				foreach (pr[j]) pr[j] = '1;
				l = 6'd32;
				m = 32'hAAAA_AAAA;
			end
			default: ;
		endcase
		foreach (pr[j]) write_reg(wbps_pkg::RegPattern0 + wbps_pkg::CfgIdxW'(j), pr[j]);
		write_reg(wbps_pkg::RegWildMask, {$urandom, m});
		write_reg(wbps_pkg::RegPatternLen, {$urandom, 26'($urandom), l});
		write_reg(wbps_pkg::RegCaseFold, {$urandom, 31'($urandom), f});
		if ($urandom_range(3) == 0) write_reg(RegUnused, {$urandom, $urandom});
	endtask

	// Streams buffers built mostly from copies of the pattern (wildcard slots
	// random, letter case scrambled when folding is on), with cut-off copies
	// and noise mixed in. The last buffer of a phase is sometimes left open so
	// the next setting is applied to a buffer in progress.
	task automatic run_phase(input int unsigned budget);
		int unsigned       sent;
		int unsigned       blen;
		int unsigned       span;
		int unsigned       cut;
		int unsigned       sel;
		logic [7:0]        bytes_q [$];
		logic [7:0]        c;
		bit                open_tail;
		wbps_pkg::result_t none;
		sent = 0;
		none = '0;
		span = (32'(pat_len) > PatMax) ? PatMax : 32'(pat_len);
		if (span == 0) span = 4;
		while (sent < budget) begin
			blen = ($urandom_range(4) == 0) ? $urandom_range(80, 25) : $urandom_range(24, 1);
			if (blen > budget - sent) blen = budget - sent;
			bytes_q.delete();
			while (bytes_q.size() < blen) begin
				sel = $urandom_range(19);
				if (sel < 12) cut = span;
				else if (sel < 15 && span > 1) cut = $urandom_range(span - 1, 1);
				else cut = 0;
				if (cut == 0) bytes_q = {bytes_q, pick_byte()};
				for (int k = 0; k < cut; k++) begin
					c = wild_bits[k] ? 8'($urandom_range(255)) : pat_reg[k/8][(k%8)*8 +: 8];
					if (fold_on && $urandom_range(1) == 1 &&
							(c | 8'h20) >= wbps_pkg::CharLowerA && (c | 8'h20) <= 8'h7A)
						c = c ^ 8'h20;
					bytes_q = {bytes_q, c};
				end
			end
			open_tail = (sent + blen >= budget) && ($urandom_range(2) == 0);
			for (int k = 0; k < blen; k++)
				push_byte(bytes_q[k], (k == blen - 1) && !open_tail, 1'b0, none);
			sent += blen;
			// Now and then the stream stops until every result is back.
			if ($urandom_range(9) == 0) drain();
		end
	endtask

	// The result side stalls at random except in the calm phases.
	always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= IdlePct);

	// Every result transfer is matched against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected result: hit=%0d offset=%0h done=%0d total=%0h",
						match_hit, match_offset, scan_done, match_total);
			end else begin
				oldest = pending_q.pop_front();
				if (match_hit !== oldest.match_hit || match_offset !== oldest.match_offset ||
						scan_done !== oldest.scan_done ||
						match_total !== oldest.match_total) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("mismatch: expected hit=%0d offset=%0h done=%0d total=%0h, %s%0d %s%0h %s%0d %s%0h",
							oldest.match_hit, oldest.match_offset, oldest.scan_done,
							oldest.match_total, "got hit=", match_hit, "offset=",
							match_offset, "done=", scan_done, "total=", match_total);
				end
			end
		end
	end

	// Watchdog for a block that stops answering.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		stim_row_t row;
		foreach (pat_reg[j]) pat_reg[j] = '0;
		clear_scan_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Straight after reset the pattern is one zero byte, so a zero byte
		// matches and anything else does not.
		add_row(fixed_row(8'h00, 1'b0, 1'b1, 32'd0, 1'b0, 32'd1));
		add_row(fixed_row(8'hFF, 1'b1, 1'b0, 32'd0, 1'b1, 32'd1));
		// Zero length: a buffer closes with no match.
		add_row(cfg_row(wbps_pkg::RegPatternLen, 64'd0));
		add_row(fixed_row(8'h00, 1'b1, 1'b0, 32'd0, 1'b1, 32'd0));
		// Pattern "aBc" with the middle byte a wildcard and folding on; the
		// second match ends on the last byte of the buffer.
		add_row(cfg_row(wbps_pkg::RegPattern0, 64'h0000_0000_0063_4261));
		add_row(cfg_row(wbps_pkg::RegWildMask, 64'h2));
		add_row(cfg_row(wbps_pkg::RegPatternLen, 64'd3));
		add_row(cfg_row(wbps_pkg::RegCaseFold, 64'd1));
		add_row(byte_row("A", 1'b0));
		add_row(byte_row("q", 1'b0));
		add_row(byte_row("C", 1'b0));
		add_row(byte_row("a", 1'b0));
		add_row(byte_row("Z", 1'b0));
		add_row(byte_row("c", 1'b1));
		// Without folding the upper-case A no longer matches.
		add_row(cfg_row(wbps_pkg::RegCaseFold, 64'd0));
		add_row(byte_row("A", 1'b0));
		add_row(byte_row("B", 1'b0));
		add_row(byte_row("c", 1'b1));
		// An oversized length is clipped to 32; one byte cannot fill the window.
		add_row(cfg_row(wbps_pkg::RegPatternLen, 64'd63));
		add_row(fixed_row("x", 1'b1, 1'b0, 32'd0, 1'b1, 32'd0));
		// A write to the unused index changes nothing.
		add_row(cfg_row(RegUnused, '1));
		// Pattern FF 00 with extreme data bytes, back-to-back matches.
		add_row(cfg_row(wbps_pkg::RegPattern0, 64'h0000_0000_0000_00FF));
		add_row(cfg_row(wbps_pkg::RegWildMask, 64'd0));
		add_row(cfg_row(wbps_pkg::RegPatternLen, 64'd2));
		add_row(byte_row(8'hFF, 1'b0));
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'hFF, 1'b0));
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'hFF, 1'b0));
		// Shortening the pattern in the middle of a buffer takes effect on the
		// next byte.
		add_row(cfg_row(wbps_pkg::RegPatternLen, 64'd1));
		add_row(byte_row(8'hFF, 1'b0));
		add_row(byte_row(8'h00, 1'b1));

		foreach (dir_rows[n]) begin
			row = dir_rows[n];
			if (row.kind == ROW_CFG) write_reg(row.idx, row.val);
			else push_byte(row.b, row.last, row.kind == ROW_FIXED, row.res);
		end

		// Random traffic, one register setting per phase. A few phases in the
		// middle run with neither side idling.
		for (int p = 0; p < NumPhases; p++) begin
			calm = (p >= 7 && p <= 9);
			setup_phase(p);
			run_phase(PhaseBytes);
		end
		calm = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (fail_cnt == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
